@@ rtl/core/xtrd_pkg.sv @@
// Shared types and constants for the XML text reference decoder.
package xtrd_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [20:0] CP_SAT         = 21'h1FFFFF;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;

    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOT     = 8'h22;
    localparam logic [7:0] CH_APOS     = 8'h27;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_F    = 8'h66;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_F     = 8'h46;
    localparam logic [7:0] CH_LOW_X    = 8'h78;
    localparam logic [7:0] CH_UP_X     = 8'h58;

    typedef enum logic [2:0] {
        SCAN_PLAIN,
        SCAN_AMP,
        SCAN_HASH,
        SCAN_HEX,
        SCAN_DEC,
        SCAN_NAME,
        SCAN_BAD
    } t_scan_mode;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_UNTERMINATED,
        ERR_EMPTY_REF,
        ERR_EMPTY_CHARREF,
        ERR_MALFORMED,
        ERR_UNDECLARED,
        ERR_CDATA_END,
        ERR_LT_IN_ATTR
    } t_err_code;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] res_byte;
        t_err_code  err;
    } t_result;

    // All results that one input byte causes, in order.
    typedef struct packed {
        logic [2:0]    count;
        t_result [3:0] slot;
    } t_group;

    typedef struct packed {
        t_scan_mode  mode;
        logic [20:0] code_point;
        logic        digits_seen;
        logic [2:0]  name_length;
        logic [1:0]  bracket_run;
        logic        failed;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode:        SCAN_PLAIN,
        code_point:  21'h0,
        digits_seen: 1'b0,
        name_length: 3'h0,
        bracket_run: 2'h0,
        failed:      1'b0
    };

endpackage

@@ rtl/core/xtrd_decode.sv @@
// Combinational decode of one text byte: next scan state and its result group.
module xtrd_decode (
    input  logic                 i_attr_mode,
    input  xtrd_pkg::t_in_item   i_item,
    input  xtrd_pkg::t_scan_state i_state,
    input  logic [3:0][7:0]      i_name_bytes,
    output xtrd_pkg::t_scan_state o_state,
    output xtrd_pkg::t_group     o_group,
    output logic                 o_name_we,
    output logic [1:0]           o_name_idx
);

    // Predefined entity names, first character in the low byte.
    localparam logic [15:0] NAME_LT   = 16'h746C;
    localparam logic [15:0] NAME_GT   = 16'h7467;
    localparam logic [23:0] NAME_AMP  = 24'h706D61;
    localparam logic [31:0] NAME_QUOT = 32'h746F7571;
    localparam logic [31:0] NAME_APOS = 32'h736F7061;

    function automatic xtrd_pkg::t_group put_res(
        input xtrd_pkg::t_group  g,
        input logic [7:0]        byt,
        input xtrd_pkg::t_err_code e
    );
        xtrd_pkg::t_group r;
        r = g;
        if (g.count < 3'(xtrd_pkg::MAX_RESULTS)) begin
            r.slot[g.count[1:0]].res_byte = byt;
            r.slot[g.count[1:0]].err      = e;
            r.count                       = g.count + 3'd1;
        end
        return r;
    endfunction

    // One digit step: multiply by the radix (16 or 10) and add, saturating.
    function automatic logic [20:0] accumulate(
        input logic [20:0] cp,
        input logic        is_hex,
        input logic [3:0]  d
    );
        logic [24:0] v;
        if (cp > xtrd_pkg::MAX_CODE_POINT) begin
            return xtrd_pkg::CP_SAT;
        end
        if (is_hex) begin
            v = {cp, 4'h0} + 25'(d);
        end else begin
            v = {1'b0, cp, 3'h0} + {3'h0, cp, 1'b0} + 25'(d);
        end
        return (v > 25'(xtrd_pkg::MAX_CODE_POINT)) ? xtrd_pkg::CP_SAT : v[20:0];
    endfunction

    logic [7:0]  b;
    logic        is_dec_digit;
    logic        is_hex_digit;
    logic [3:0]  hex_val;
    logic        is_ws;
    logic [20:0] cp_out;
    logic        name_ok;
    logic [7:0]  name_char;

    assign b = i_item.text_byte;
    assign is_dec_digit = (b >= xtrd_pkg::CH_0) && (b <= xtrd_pkg::CH_9);
    assign is_ws = (b == xtrd_pkg::CH_SPACE) || (b == xtrd_pkg::CH_TAB) ||
                   (b == xtrd_pkg::CH_CR) || (b == xtrd_pkg::CH_LF);

    always_comb begin
        is_hex_digit = 1'b1;
        hex_val      = 4'h0;
        if (is_dec_digit) begin
            hex_val = 4'(b - xtrd_pkg::CH_0);
        end else if (b >= xtrd_pkg::CH_LOW_A && b <= xtrd_pkg::CH_LOW_F) begin
            hex_val = 4'(b - xtrd_pkg::CH_LOW_A + 8'd10);
        end else if (b >= xtrd_pkg::CH_UP_A && b <= xtrd_pkg::CH_UP_F) begin
            hex_val = 4'(b - xtrd_pkg::CH_UP_A + 8'd10);
        end else begin
            is_hex_digit = 1'b0;
        end
    end

    // Zero, surrogates and anything past the Unicode range become U+FFFD.
    always_comb begin
        cp_out = i_state.code_point;
        if (cp_out > xtrd_pkg::MAX_CODE_POINT || cp_out == 21'h0 ||
            (cp_out >= xtrd_pkg::SURROGATE_LO && cp_out <= xtrd_pkg::SURROGATE_HI)) begin
            cp_out = xtrd_pkg::REPLACEMENT_CP;
        end
    end

    always_comb begin
        name_ok   = 1'b1;
        name_char = xtrd_pkg::CH_LT;
        priority if (i_state.name_length == 3'd2 && i_name_bytes[1:0] == NAME_LT) begin
            name_char = xtrd_pkg::CH_LT;
        end else if (i_state.name_length == 3'd2 && i_name_bytes[1:0] == NAME_GT) begin
            name_char = xtrd_pkg::CH_GT;
        end else if (i_state.name_length == 3'd3 && i_name_bytes[2:0] == NAME_AMP) begin
            name_char = xtrd_pkg::CH_AMP;
        end else if (i_state.name_length == 3'd4 && i_name_bytes == NAME_QUOT) begin
            name_char = xtrd_pkg::CH_QUOT;
        end else if (i_state.name_length == 3'd4 && i_name_bytes == NAME_APOS) begin
            name_char = xtrd_pkg::CH_APOS;
        end else begin
            name_ok = 1'b0;
        end
    end

    always_comb begin
        xtrd_pkg::t_scan_state ns;
        xtrd_pkg::t_group      g;
        ns         = i_state;
        g          = '0;
        o_name_we  = 1'b0;
        o_name_idx = i_state.name_length[1:0];

        if (!i_state.failed) begin
            unique case (i_state.mode)
                xtrd_pkg::SCAN_PLAIN: begin
                    if (!i_attr_mode && b == xtrd_pkg::CH_RBRACKET) begin
                        if (i_state.bracket_run >= 2'd2) begin
                            g = put_res(g, xtrd_pkg::CH_RBRACKET, xtrd_pkg::ERR_NONE);
                        end else begin
                            ns.bracket_run = i_state.bracket_run + 2'd1;
                        end
                    end else if (!i_attr_mode && b == xtrd_pkg::CH_GT &&
                                 i_state.bracket_run >= 2'd2) begin
                        ns.bracket_run = 2'd0;
                        g              = put_res(g, 8'h00, xtrd_pkg::ERR_CDATA_END);
                        ns.failed      = 1'b1;
                    end else begin
                        if (i_state.bracket_run >= 2'd1) begin
                            g = put_res(g, xtrd_pkg::CH_RBRACKET, xtrd_pkg::ERR_NONE);
                        end
                        if (i_state.bracket_run >= 2'd2) begin
                            g = put_res(g, xtrd_pkg::CH_RBRACKET, xtrd_pkg::ERR_NONE);
                        end
                        ns.bracket_run = 2'd0;
                        if (i_attr_mode && b == xtrd_pkg::CH_LT) begin
                            g         = put_res(g, 8'h00, xtrd_pkg::ERR_LT_IN_ATTR);
                            ns.failed = 1'b1;
                        end else if (b == xtrd_pkg::CH_AMP) begin
                            ns.mode        = xtrd_pkg::SCAN_AMP;
                            ns.code_point  = 21'h0;
                            ns.digits_seen = 1'b0;
                            ns.name_length = 3'd0;
                        end else if (i_attr_mode && is_ws) begin
                            g = put_res(g, xtrd_pkg::CH_SPACE, xtrd_pkg::ERR_NONE);
                        end else begin
                            g = put_res(g, b, xtrd_pkg::ERR_NONE);
                        end
                    end
                end
                xtrd_pkg::SCAN_AMP: begin
                    if (b == xtrd_pkg::CH_SEMI) begin
                        g         = put_res(g, 8'h00, xtrd_pkg::ERR_EMPTY_REF);
                        ns.failed = 1'b1;
                    end else if (b == xtrd_pkg::CH_HASH) begin
                        ns.mode = xtrd_pkg::SCAN_HASH;
                    end else begin
                        o_name_we      = 1'b1;
                        o_name_idx     = 2'd0;
                        ns.name_length = 3'd1;
                        ns.mode        = xtrd_pkg::SCAN_NAME;
                    end
                end
                xtrd_pkg::SCAN_HASH: begin
                    if (b == xtrd_pkg::CH_SEMI) begin
                        g         = put_res(g, 8'h00, xtrd_pkg::ERR_EMPTY_CHARREF);
                        ns.failed = 1'b1;
                    end else if (b == xtrd_pkg::CH_LOW_X || b == xtrd_pkg::CH_UP_X) begin
                        ns.mode        = xtrd_pkg::SCAN_HEX;
                        ns.digits_seen = 1'b0;
                    end else if (is_dec_digit) begin
                        ns.code_point  = accumulate(i_state.code_point, 1'b0, hex_val);
                        ns.digits_seen = 1'b1;
                        ns.mode        = xtrd_pkg::SCAN_DEC;
                    end else begin
                        ns.mode = xtrd_pkg::SCAN_BAD;
                    end
                end
                xtrd_pkg::SCAN_HEX, xtrd_pkg::SCAN_DEC: begin
                    if (b == xtrd_pkg::CH_SEMI) begin
                        if (!i_state.digits_seen) begin
                            g         = put_res(g, 8'h00, xtrd_pkg::ERR_EMPTY_CHARREF);
                            ns.failed = 1'b1;
                        end else begin
                            if (cp_out < 21'h80) begin
                                g = put_res(g, {1'b0, cp_out[6:0]}, xtrd_pkg::ERR_NONE);
                            end else if (cp_out < 21'h800) begin
                                g = put_res(g, {3'b110, cp_out[10:6]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[5:0]}, xtrd_pkg::ERR_NONE);
                            end else if (cp_out < 21'h10000) begin
                                g = put_res(g, {4'b1110, cp_out[15:12]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[11:6]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[5:0]}, xtrd_pkg::ERR_NONE);
                            end else begin
                                g = put_res(g, {5'b11110, cp_out[20:18]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[17:12]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[11:6]}, xtrd_pkg::ERR_NONE);
                                g = put_res(g, {2'b10, cp_out[5:0]}, xtrd_pkg::ERR_NONE);
                            end
                            ns.mode = xtrd_pkg::SCAN_PLAIN;
                        end
                    end else if (i_state.mode == xtrd_pkg::SCAN_HEX ? is_hex_digit
                                                                     : is_dec_digit) begin
                        ns.code_point  = accumulate(i_state.code_point,
                                                    i_state.mode == xtrd_pkg::SCAN_HEX,
                                                    hex_val);
                        ns.digits_seen = 1'b1;
                    end else begin
                        ns.mode = xtrd_pkg::SCAN_BAD;
                    end
                end
                xtrd_pkg::SCAN_NAME: begin
                    if (b == xtrd_pkg::CH_SEMI) begin
                        if (name_ok) begin
                            g       = put_res(g, name_char, xtrd_pkg::ERR_NONE);
                            ns.mode = xtrd_pkg::SCAN_PLAIN;
                        end else begin
                            g         = put_res(g, 8'h00, xtrd_pkg::ERR_UNDECLARED);
                            ns.failed = 1'b1;
                        end
                    end else if (i_state.name_length < 3'd4) begin
                        o_name_we      = 1'b1;
                        ns.name_length = i_state.name_length + 3'd1;
                    end else begin
                        ns.name_length = 3'd5;
                    end
                end
                default: begin
                    if (b == xtrd_pkg::CH_SEMI) begin
                        g         = put_res(g, 8'h00, xtrd_pkg::ERR_MALFORMED);
                        ns.failed = 1'b1;
                    end
                end
            endcase

            if (i_item.end_of_text && !ns.failed) begin
                if (ns.mode != xtrd_pkg::SCAN_PLAIN) begin
                    g = put_res(g, 8'h00, xtrd_pkg::ERR_UNTERMINATED);
                end else begin
                    if (ns.bracket_run >= 2'd1) begin
                        g = put_res(g, xtrd_pkg::CH_RBRACKET, xtrd_pkg::ERR_NONE);
                    end
                    if (ns.bracket_run >= 2'd2) begin
                        g = put_res(g, xtrd_pkg::CH_RBRACKET, xtrd_pkg::ERR_NONE);
                    end
                end
            end
        end

        if (i_item.end_of_text) begin
            ns = xtrd_pkg::SCAN_RESET;
        end

        o_state = ns;
        o_group = g;
    end

endmodule

@@ rtl/core/xml_text_reference_decoder_core.sv @@
// Top level of the XML text reference decoder: scan state, result group and output register.
// Each result passes through the result group register and then the output register.
// Throughput: one result transfer per cycle while i_out_stall is low; a byte is taken
// every cycle while each byte yields at most one result; a byte with several results holds
// off the next byte while the result group register drains them one entry a cycle.
// Reset (synchronous, i_rst_n low) returns the scan state, mode and both buffers to empty.
module xml_text_reference_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xtrd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xtrd_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    // The attribute mode register is written from its own port and is read by the
    // decoder at every byte, so a change takes effect at the next byte.
    logic r_attr_mode;

    // Scan state of the current text run and the name bytes of an open entity
    // reference. Name bytes are only read after they were written in the same
    // reference, so they carry no reset.
    xtrd_pkg::t_scan_state r_state;
    xtrd_pkg::t_scan_state n_state;
    logic [3:0][7:0]       r_name_bytes;

    // Result group: every result one byte causes, drained head first.
    logic [2:0]             r_grp_count;
    logic [1:0]             r_grp_head;
    xtrd_pkg::t_result [3:0] r_grp_slot;

    // Output register that parts the result group from the downstream side.
    logic                r_out_valid;
    xtrd_pkg::t_out_item r_out;

    xtrd_pkg::t_group dec_group;
    logic             dec_name_we;
    logic [1:0]       dec_name_idx;

    logic in_accept;
    logic out_take;
    logic move;

    assign o_cfg_ready = 1'b1;

    // A result moves from the group into the output register whenever that
    // register is empty or its content is taken in this cycle.
    assign out_take = r_out_valid && !i_out_stall;
    assign move     = (r_grp_count != 3'd0) && (!r_out_valid || out_take);

    // A new byte is taken when the group will be empty at the next edge, so a
    // stream of single-result bytes moves at one byte per cycle while i_out_stall is low.
    assign o_in_stall = (r_grp_count > 3'd1) || (r_grp_count == 3'd1 && !move);
    assign in_accept  = i_in_valid && !o_in_stall;

    xtrd_decode u_decode (
        .i_attr_mode  (r_attr_mode),
        .i_item       (i_in),
        .i_state      (r_state),
        .i_name_bytes (r_name_bytes),
        .o_state      (n_state),
        .o_group      (dec_group),
        .o_name_we    (dec_name_we),
        .o_name_idx   (dec_name_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xtrd_pkg::SCAN_RESET;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && dec_name_we) begin
            r_name_bytes[dec_name_idx] <= i_in.text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_count <= 3'd0;
            r_grp_head  <= 2'd0;
        end else if (in_accept) begin
            r_grp_count <= dec_group.count;
            r_grp_head  <= 2'd0;
        end else if (move) begin
            r_grp_count <= r_grp_count - 3'd1;
            r_grp_head  <= r_grp_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_grp_slot <= dec_group.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // The last flag marks the final entry of a group.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.out_byte   <= r_grp_slot[r_grp_head].res_byte;
            r_out.error_code <= 3'(r_grp_slot[r_grp_head].err);
            r_out.last       <= (r_grp_count == 3'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ test/xtrd_decode_checker.sv @@
// Checker for the XML text reference decoder: predicts decoded bytes and compares each result.
module xtrd_decode_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  xtrd_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  xtrd_pkg::t_out_item i_out,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    output int                  o_failures,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import xtrd_pkg::*;

    // Shadow copy of the decoder state.
    logic        attr_mode;
    t_scan_mode  scan;
    logic [20:0] char_value;
    logic        have_digits;
    logic [7:0]  name_buf [4];
    logic [2:0]  name_len;
    logic [1:0]  held_brackets;
    logic        run_failed;

    t_out_item decoded_now[$];
    t_out_item decoded_queue[$];

    function automatic void emit(input logic [7:0] b, input t_err_code err);
        t_out_item res;
        res = '{out_byte: b, error_code: err, last: 1'b0};
        if (decoded_now.size() < MAX_RESULTS)
            decoded_now = {decoded_now, res};
    endfunction

    function automatic void raise_error(input t_err_code err);
        emit(8'h00, err);
        run_failed = 1'b1;
    endfunction

    function automatic void clear_run_state();
        scan          = SCAN_PLAIN;
        char_value    = '0;
        have_digits   = 1'b0;
        name_len      = '0;
        held_brackets = '0;
        run_failed    = 1'b0;
    endfunction

    function automatic void release_brackets();
        while (held_brackets > 0) begin
            emit(CH_RBRACKET, ERR_NONE);
            held_brackets = held_brackets - 2'd1;
        end
    endfunction

    function automatic int digit_weight(input logic [7:0] b);
        if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
        if (b >= CH_LOW_A && b <= CH_LOW_F) return int'(b - CH_LOW_A) + 10;
        if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
        return -1;
    endfunction

    // Once past the top of the code space the value sticks at the saturated code.
    function automatic void add_digit(input int unsigned radix, input int unsigned digit);
        int unsigned sum;
        if (char_value > MAX_CODE_POINT) begin
            char_value = CP_SAT;
            return;
        end
        sum = int'(char_value) * radix + digit;
        char_value = (sum > MAX_CODE_POINT) ? CP_SAT : sum[20:0];
    endfunction

    function automatic void emit_utf8();
        logic [20:0] c;
        c = char_value;
        if (c > MAX_CODE_POINT || c == 0 || (c >= SURROGATE_LO && c <= SURROGATE_HI))
            c = REPLACEMENT_CP;
        if (c < 21'h80) begin
            emit(c[7:0], ERR_NONE);
        end else if (c < 21'h800) begin
            emit({3'b110, c[10:6]}, ERR_NONE);
            emit({2'b10, c[5:0]}, ERR_NONE);
        end else if (c < 21'h10000) begin
            emit({4'b1110, c[15:12]}, ERR_NONE);
            emit({2'b10, c[11:6]}, ERR_NONE);
            emit({2'b10, c[5:0]}, ERR_NONE);
        end else begin
            emit({5'b11110, c[20:18]}, ERR_NONE);
            emit({2'b10, c[17:12]}, ERR_NONE);
            emit({2'b10, c[11:6]}, ERR_NONE);
            emit({2'b10, c[5:0]}, ERR_NONE);
        end
    endfunction

    function automatic bit name_matches(input string s);
        if (name_len != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (name_buf[i] != s.getc(i)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_entity();
        if (name_matches("lt")) emit(CH_LT, ERR_NONE);
        else if (name_matches("gt")) emit(CH_GT, ERR_NONE);
        else if (name_matches("amp")) emit(CH_AMP, ERR_NONE);
        else if (name_matches("quot")) emit(CH_QUOT, ERR_NONE);
        else if (name_matches("apos")) emit(CH_APOS, ERR_NONE);
        else begin
            raise_error(ERR_UNDECLARED);
            return;
        end
        scan = SCAN_PLAIN;
    endfunction

    function automatic void plain_text(input logic [7:0] b);
        if (!attr_mode && b == CH_RBRACKET) begin
            if (held_brackets >= 2) emit(CH_RBRACKET, ERR_NONE);
            else held_brackets = held_brackets + 2'd1;
            return;
        end
        if (!attr_mode && b == CH_GT && held_brackets >= 2) begin
            held_brackets = '0;
            raise_error(ERR_CDATA_END);
            return;
        end
        release_brackets();
        if (attr_mode && b == CH_LT) begin
            raise_error(ERR_LT_IN_ATTR);
        end else if (b == CH_AMP) begin
            scan        = SCAN_AMP;
            char_value  = '0;
            have_digits = 1'b0;
            name_len    = '0;
        end else if (attr_mode && (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
            emit(CH_SPACE, ERR_NONE);
        end else begin
            emit(b, ERR_NONE);
        end
    endfunction

    // Works out every result one accepted byte causes and queues them in order.
    function automatic void decode_byte(input logic [7:0] b, input logic run_end);
        int digit;
        decoded_now.delete();
        if (!run_failed) begin
            case (scan)
                SCAN_PLAIN: plain_text(b);
                SCAN_AMP: begin
                    if (b == CH_SEMI) raise_error(ERR_EMPTY_REF);
                    else if (b == CH_HASH) scan = SCAN_HASH;
                    else begin
                        name_buf[0] = b;
                        name_len    = 3'd1;
                        scan        = SCAN_NAME;
                    end
                end
                SCAN_HASH: begin
                    if (b == CH_SEMI) raise_error(ERR_EMPTY_CHARREF);
                    else if (b == CH_LOW_X || b == CH_UP_X) begin
                        scan        = SCAN_HEX;
                        have_digits = 1'b0;
                    end else if (b >= CH_0 && b <= CH_9) begin
                        add_digit(10, int'(b - CH_0));
                        have_digits = 1'b1;
                        scan        = SCAN_DEC;
                    end else scan = SCAN_BAD;
                end
                SCAN_HEX: begin
                    if (b == CH_SEMI) begin
                        if (!have_digits) raise_error(ERR_EMPTY_CHARREF);
                        else begin
                            emit_utf8();
                            scan = SCAN_PLAIN;
                        end
                    end else begin
                        digit = digit_weight(b);
                        if (digit < 0) scan = SCAN_BAD;
                        else begin
                            add_digit(16, digit);
                            have_digits = 1'b1;
                        end
                    end
                end
                SCAN_DEC: begin
                    if (b == CH_SEMI) begin
                        emit_utf8();
                        scan = SCAN_PLAIN;
                    end else if (b >= CH_0 && b <= CH_9) add_digit(10, int'(b - CH_0));
                    else scan = SCAN_BAD;
                end
                SCAN_NAME: begin
                    if (b == CH_SEMI) close_entity();
                    else if (name_len < 4) begin
                        name_buf[name_len] = b;
                        name_len = name_len + 3'd1;
                    end else name_len = 3'd5;
                end
                default: begin
                    if (b == CH_SEMI) raise_error(ERR_MALFORMED);
                end
            endcase
            if (run_end && !run_failed) begin
                if (scan != SCAN_PLAIN) raise_error(ERR_UNTERMINATED);
                else release_brackets();
            end
        end
        if (run_end) clear_run_state();
        if (decoded_now.size() > 0) decoded_now[decoded_now.size() - 1].last = 1'b1;
        decoded_queue = {decoded_queue, decoded_now};
    endfunction

    function automatic void compare_result(input t_out_item got);
        t_out_item want;
        if (decoded_queue.size() == 0) begin
            $error("unexpected result: out_byte 0x%02h error_code %0d last %0b",
                   got.out_byte, got.error_code, got.last);
            o_failures++;
            return;
        end
        want = decoded_queue.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
            o_failures++;
        end
        if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            o_failures++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            o_failures++;
        end
    endfunction

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    // Inputs are sampled at the edge before the testbench or the block updates them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attr_mode = 1'b0;
            clear_run_state();
            decoded_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) attr_mode = i_cfg_data;
            if (i_in_valid && !i_in_stall) decode_byte(i_in.text_byte, i_in.end_of_text);
            if (i_out_valid && !i_out_stall) compare_result(i_out);
        end
        o_pending = decoded_queue.size();
    end

endmodule

@@ test/xml_text_reference_decoder_core_test.sv @@
// Testbench top for the XML text reference decoder: clock, reset, text stimulus and verdict.
module xml_text_reference_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xtrd_pkg::*;

    // Cycles to wait once the last expected result is in. This also covers bytes
    // that cause no result and are still in flight.
    localparam int SETTLE_CYCLES = 8;
    // A long receiver hold-off while the sender keeps offering bytes.
    localparam int HOLD_CYCLES   = 300;
    // Watchdog limit, set well above the slowest correct run.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 100;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    int failures;
    int pending;

    // Idle and stall rates, in percent, for the current phase.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;

    // The main process flips hold_toggle to ask for a hold-off; the stall process
    // notices the change and counts the stretch out on its own.
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    // Bytes of the text run being built.
    logic [7:0] run_bytes[$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    xml_text_reference_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    xtrd_decode_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // Receiver side: random stalls at the phase's rate, or a solid hold-off on request.
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: a run that has not finished by the limit is a failure.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offers one byte and returns at the edge where its transfer happens. Idle cycles
    // come before the byte is offered, so valid never drops while a byte is waiting.
    task automatic send_byte(input logic [7:0] b, input logic run_end);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{text_byte: b, end_of_text: run_end};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Sends the built run; its last byte carries the end-of-text flag.
    task automatic send_run();
        for (int i = 0; i < run_bytes.size(); i++)
            send_byte(run_bytes[i], i == run_bytes.size() - 1);
        run_bytes.delete();
    endtask

    // Stops offering bytes and waits until every expected result has come out.
    // The checker's count may lag behind, but with no new transfers it only
    // falls, so a zero read here is always real.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The mode register is only written while the decoder is idle.
    task automatic write_attribute_mode(input logic mode);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        run_bytes = {run_bytes, b};
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s.getc(i));
    endfunction

    // Code points spread over every UTF-8 length plus zero, surrogates and values
    // past the top of the code space, which must come out as the replacement char.
    function automatic int unsigned pick_code_point();
        case ($urandom_range(7))
            0:       return 0;
            1:       return $urandom_range(32'h7F, 32'h1);
            2:       return $urandom_range(32'h7FF, 32'h80);
            3:       return $urandom_range(32'hFFFF, 32'h800);
            4:       return $urandom_range(32'h10FFFF, 32'h10000);
            5:       return $urandom_range(32'hDFFF, 32'hD800);
            6:       return $urandom_range(32'hFFFFFF, 32'h110000);
            default: return $urandom_range(32'h10FFFF, 32'h10FFF0);
        endcase
    endfunction

    function automatic void add_plain_byte();
        case ($urandom_range(5))
            0, 1, 2: add_byte(8'($urandom_range(255)));
            3: repeat ($urandom_range(3, 1)) add_byte(CH_RBRACKET);
            4: add_byte(CH_GT);
            default: begin
                case ($urandom_range(4))
                    0:       add_byte(CH_SPACE);
                    1:       add_byte(CH_TAB);
                    2:       add_byte(CH_CR);
                    3:       add_byte(CH_LF);
                    default: add_byte(CH_LT);
                endcase
            end
        endcase
    endfunction

    // References that go wrong: empty, no digits, a bad digit, a body holding '<'.
    function automatic void add_broken_ref();
        case ($urandom_range(5))
            0: put_str("&;");
            1: put_str("&#;");
            2: put_str("&#x;");
            3: begin
                put_str("&#");
                add_byte(8'($urandom_range(255)));
                put_str("1;");
            end
            4: begin
                put_str("&#x1");
                add_byte(8'($urandom_range(8'h7A, 8'h67)));
                put_str(";");
            end
            default: put_str("&a<b;");
        endcase
    endfunction

    // One piece of a text run; most pieces are well-formed references or plain text.
    function automatic void add_segment();
        int unsigned pick;
        string digits;
        string prefix;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 30) begin
            add_plain_byte();
        end else if (pick < 45) begin
            case ($urandom_range(4))
                0:       put_str("&lt;");
                1:       put_str("&gt;");
                2:       put_str("&amp;");
                3:       put_str("&quot;");
                default: put_str("&apos;");
            endcase
        end else if (pick < 58) begin
            put_str($sformatf("&#%0d;", pick_code_point()));
        end else if (pick < 72) begin
            digits = $sformatf("%0h", pick_code_point());
            for (int i = 0; i < digits.len(); i++) begin
                c = digits.getc(i);
                if (c >= CH_LOW_A && $urandom_range(1)) digits.putc(i, c - 8'd32);
            end
            prefix = $urandom_range(1) ? "&#x" : "&#X";
            put_str(prefix);
            if ($urandom_range(3) == 0) put_str("00");
            put_str(digits);
            put_str(";");
        end else if (pick < 80) begin
            // Names of one to six letters; almost all of them are undeclared.
            add_byte(CH_AMP);
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(8'h7A, 8'h61)));
            add_byte(CH_SEMI);
        end else if (pick < 92) begin
            add_broken_ref();
        end else begin
            repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
        end
    endfunction

    // A run of one to six pieces; now and then it ends inside an open reference.
    function automatic void build_run();
        repeat ($urandom_range(6, 1)) add_segment();
        if ($urandom_range(7) == 0) begin
            if ($urandom_range(1)) put_str("&#");
            else put_str("&q");
        end
    endfunction

    task automatic random_runs(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            build_run();
            send_run();
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Element content: byte extremes, held brackets with a third one released
        // and the "]]>" error, a zero character reference and the empty references.
        write_attribute_mode(1'b0);
        add_byte(8'h00);
        send_run();
        add_byte(8'hFF);
        send_run();
        put_str("]]]>");
        send_run();
        put_str("&#0;");
        send_run();
        put_str("&;");
        send_run();
        put_str("&#;");
        send_run();

        // Attribute value: '<' is an error, white space folds to a space, and a
        // reference left open at the end of the run is unterminated.
        write_attribute_mode(1'b1);
        put_str("<");
        send_run();
        put_str(" \t");
        send_run();
        put_str("&amp");
        send_run();

        // Random runs under each idling pattern, alternating the mode.
        for (int phase = 0; phase < 4; phase++) begin
            write_attribute_mode(phase % 2 == 1);
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 45;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 45;
                end
                default: begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            random_runs(PHASE_ITEMS);
        end

        // Back-pressure: the receiver holds off while bytes keep coming, so the
        // result buffer fills and the input side has to stall.
        write_attribute_mode(1'($urandom_range(1)));
        idle_pct  = 0;
        stall_pct = 0;
        hold_toggle <= ~hold_toggle;
        random_runs(60);

        wait_for_idle();
        if (failures == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
